/* rtl/gpio_irq_pkg.sv */
// Shared types, command and register codes for the GPIO port with interrupt detection.
package gpio_irq_pkg;

    // Port geometry
    localparam int unsigned PIN_COUNT = 32;
    localparam int unsigned HALF_PINS = 16;
    localparam logic [31:0] PIN_MASK  = (PIN_COUNT >= 32) ? 32'hFFFF_FFFF :
                                        ((32'd1 << PIN_COUNT) - 32'd1);

    // Request commands
    localparam logic [1:0] CMD_READ   = 2'd0;
    localparam logic [1:0] CMD_WRITE  = 2'd1;
    localparam logic [1:0] CMD_TICK   = 2'd2;
    localparam logic [1:0] CMD_UNUSED = 2'd3;

    // Register map
    localparam logic [2:0] REG_DATA     = 3'd0;
    localparam logic [2:0] REG_DIR      = 3'd1;
    localparam logic [2:0] REG_PAD      = 3'd2;
    localparam logic [2:0] REG_ICR_LO   = 3'd3;
    localparam logic [2:0] REG_ICR_HI   = 3'd4;
    localparam logic [2:0] REG_MASK     = 3'd5;
    localparam logic [2:0] REG_STATUS   = 3'd6;
    localparam logic [2:0] REG_ANY_EDGE = 3'd7;

    // Interrupt control codes, two bits per pin
    localparam logic [1:0] TRIG_LOW  = 2'd0;
    localparam logic [1:0] TRIG_HIGH = 2'd1;
    localparam logic [1:0] TRIG_RISE = 2'd2;
    localparam logic [1:0] TRIG_FALL = 2'd3;

    // Request payload
    typedef struct packed {
        logic [1:0]  command;
        logic [2:0]  reg_index;
        logic [31:0] write_data;
        logic [31:0] pin_levels;
    } gpio_req_t;

    // Response payload
    typedef struct packed {
        logic [31:0] read_data;
        logic [31:0] pad_drive;
        logic [31:0] pad_enable;
        logic        irq_low_half;
        logic        irq_high_half;
    } gpio_rsp_t;

    // Trigger configuration handed to the detector
    typedef struct packed {
        logic [31:0] icr_lower;
        logic [31:0] icr_upper;
        logic [31:0] any_edge;
    } gpio_trig_cfg_t;

endpackage

/* rtl/gpio_irq_detect.sv */
// Per-pin level and edge trigger detection for one pad sample.
module gpio_irq_detect
    import gpio_irq_pkg::*;
(
    input  logic [31:0]    levels,
    input  logic [31:0]    prev_levels,
    input  gpio_trig_cfg_t cfg,
    output logic [31:0]    hit
);

    logic [31:0] rise;
    logic [31:0] fall;
    logic [31:0] fire;

    // Edges against the previous sample
    assign rise = levels & ~prev_levels;
    assign fall = prev_levels & ~levels;

    // One trigger decoder per pin
    for (genvar i = 0; i < 32; i++) begin : g_pin
        logic [31:0] word;
        logic [1:0]  code;
        logic        fire_bit;

        assign word = (i < HALF_PINS) ? cfg.icr_lower : cfg.icr_upper;
        assign code = word[(i % HALF_PINS) * 2 +: 2];

        always_comb
        begin
            if (cfg.any_edge[i])
            begin
                fire_bit = rise[i] | fall[i];
            end
            else
            begin
                unique case (code)
                    TRIG_LOW:  fire_bit = ~levels[i];
                    TRIG_HIGH: fire_bit = levels[i];
                    TRIG_RISE: fire_bit = rise[i];
                    TRIG_FALL: fire_bit = fall[i];
                endcase
            end
        end

        assign fire[i] = fire_bit;
    end

    // Absent pins never fire
    assign hit = fire & PIN_MASK;

endmodule

/* rtl/gpio_port_with_interrupt_detect_unit.sv */
// Top level of the 32-pin GPIO port: register file, pad sampling and interrupt lines.
//
//   channel | direction | handshake            | payload
//   --------+-----------+----------------------+-----------
//   req     | in        | req_valid/req_ready  | gpio_req_t
//   rsp     | out       | rsp_valid/rsp_ready  | gpio_rsp_t
//
// One request per clock unless rsp stalls; each yields exactly one response next cycle.
// Register state updates in the cycle the request is taken; the response register
// holds the read data and the post-update drive, enable and interrupt lines.
// rsp stalls back-pressure req only when the response register is still full.
// Reset clears state registers and rsp_valid: all pins inputs, all interrupts masked.
module gpio_port_with_interrupt_detect_unit
    import gpio_irq_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      req_valid,
    output logic      req_ready,
    input  gpio_req_t req,
    output logic      rsp_valid,
    input  logic      rsp_ready,
    output gpio_rsp_t rsp
);

    // Architectural registers; the pad status register also serves as the previous sample
    logic [31:0] data_out_reg,   data_out_next;
    logic [31:0] direction_reg,  direction_next;
    logic [31:0] pad_status_reg, pad_status_next;
    logic [31:0] icr_lower_reg,  icr_lower_next;
    logic [31:0] icr_upper_reg,  icr_upper_next;
    logic [31:0] irq_mask_reg,   irq_mask_next;
    logic [31:0] irq_status_reg, irq_status_next;
    logic [31:0] any_edge_reg,   any_edge_next;

    gpio_rsp_t   rsp_reg, rsp_next;
    logic        rsp_valid_reg;

    logic        req_fire;
    logic [31:0] levels;
    logic [31:0] wdata_pins;
    logic [31:0] hit;
    logic [31:0] rdata;
    logic [31:0] pending;
    gpio_trig_cfg_t trig_cfg;

    assign req_ready = ~rsp_valid_reg | rsp_ready;
    assign req_fire  = req_valid & req_ready;
    assign levels    = req.pin_levels & PIN_MASK;
    assign wdata_pins = req.write_data & PIN_MASK;

    assign trig_cfg.icr_lower = icr_lower_reg;
    assign trig_cfg.icr_upper = icr_upper_reg;
    assign trig_cfg.any_edge  = any_edge_reg;

    gpio_irq_detect u_detect (
        .levels      (levels),
        .prev_levels (pad_status_reg),
        .cfg         (trig_cfg),
        .hit         (hit)
    );

    // Request decode and next state
    always_comb
    begin
        data_out_next   = data_out_reg;
        direction_next  = direction_reg;
        pad_status_next = pad_status_reg;
        icr_lower_next  = icr_lower_reg;
        icr_upper_next  = icr_upper_reg;
        irq_mask_next   = irq_mask_reg;
        irq_status_next = irq_status_reg;
        any_edge_next   = any_edge_reg;
        rdata           = '0;

        unique case (req.command)
            CMD_READ:
            begin
                unique case (req.reg_index)
                    REG_DATA:     rdata = (data_out_reg & direction_reg) |
                                          (pad_status_reg & ~direction_reg);
                    REG_DIR:      rdata = direction_reg;
                    REG_PAD:      rdata = pad_status_reg;
                    REG_ICR_LO:   rdata = icr_lower_reg;
                    REG_ICR_HI:   rdata = icr_upper_reg;
                    REG_MASK:     rdata = irq_mask_reg;
                    REG_STATUS:   rdata = irq_status_reg;
                    REG_ANY_EDGE: rdata = any_edge_reg;
                endcase
            end
            CMD_WRITE:
            begin
                unique case (req.reg_index)
                    REG_DATA:     data_out_next  = wdata_pins;
                    REG_DIR:      direction_next = wdata_pins;
                    REG_PAD:      ;  // read only
                    REG_ICR_LO:   icr_lower_next = req.write_data;
                    REG_ICR_HI:   icr_upper_next = req.write_data;
                    REG_MASK:     irq_mask_next  = wdata_pins;
                    REG_STATUS:   irq_status_next = irq_status_reg & ~wdata_pins;
                    REG_ANY_EDGE: any_edge_next  = wdata_pins;
                endcase
            end
            CMD_TICK:
            begin
                irq_status_next = irq_status_reg | hit;
                pad_status_next = levels;
            end
            CMD_UNUSED: ;
        endcase
    end

    // Response from post-update state
    always_comb
    begin
        pending                = irq_status_next & irq_mask_next;
        rsp_next.read_data     = rdata;
        rsp_next.pad_drive     = data_out_next;
        rsp_next.pad_enable    = direction_next;
        rsp_next.irq_low_half  = |pending[15:0];
        rsp_next.irq_high_half = |pending[31:16];
    end

    // State registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            data_out_reg   <= '0;
            direction_reg  <= '0;
            pad_status_reg <= '0;
            icr_lower_reg  <= '0;
            icr_upper_reg  <= '0;
            irq_mask_reg   <= '0;
            irq_status_reg <= '0;
            any_edge_reg   <= '0;
        end
        else if (req_fire)
        begin
            data_out_reg   <= data_out_next;
            direction_reg  <= direction_next;
            pad_status_reg <= pad_status_next;
            icr_lower_reg  <= icr_lower_next;
            icr_upper_reg  <= icr_upper_next;
            irq_mask_reg   <= irq_mask_next;
            irq_status_reg <= irq_status_next;
            any_edge_reg   <= any_edge_next;
        end
    end

    // Response valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else if (req_fire)
        begin
            rsp_valid_reg <= 1'b1;
        end
        else if (rsp_ready)
        begin
            rsp_valid_reg <= 1'b0;
        end
    end

    // Response payload
    always_ff @(posedge clk)
    begin
        if (req_fire)
        begin
            rsp_reg <= rsp_next;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    // Every taken request yields a response next cycle
    a_req_gives_rsp: assert property (@(posedge clk) disable iff (!rst_n)
        req_fire |=> rsp_valid)
        else $error("request taken without a response");

    // Only reads return data
    a_read_data_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (req_fire && req.command != CMD_READ) |=> (rsp.read_data == 32'd0))
        else $error("non-read request returned data");

    // Status bits are sticky unless cleared by a status write
    a_status_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        !(req_fire && req.command == CMD_WRITE && req.reg_index == REG_STATUS)
        |=> ((irq_status_reg & $past(irq_status_reg)) == $past(irq_status_reg)))
        else $error("interrupt status bit lost");

    // Pending response tracks the live drive and enable registers
    a_rsp_tracks_pads: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> (rsp.pad_drive == data_out_reg && rsp.pad_enable == direction_reg))
        else $error("response pad fields out of step with registers");

endmodule

/* tb/gpio_port_with_interrupt_detect_unit_tb.sv */
// Self-checking testbench for the 32-pin GPIO port with interrupt detection.
module gpio_port_with_interrupt_detect_unit_tb;
    import gpio_irq_pkg::*;

    localparam int HOLD_CYCLES = 60;
    localparam int STALL_LIMIT = 2000;
    localparam logic [31:0] ONES = 32'hFFFF_FFFF;

    logic      clk;
    logic      rst_n;
    logic      req_valid;
    logic      req_ready;
    gpio_req_t req;
    logic      rsp_valid;
    logic      rsp_ready;
    gpio_rsp_t rsp;

    // Shadow copy of the port's registers
    logic [31:0] sh_data_out    = '0;
    logic [31:0] sh_direction   = '0;
    logic [31:0] sh_pad_status  = '0;
    logic [31:0] sh_prev_levels = '0;
    logic [31:0] sh_icr_lower   = '0;
    logic [31:0] sh_icr_upper   = '0;
    logic [31:0] sh_irq_mask    = '0;
    logic [31:0] sh_irq_status  = '0;
    logic [31:0] sh_any_edge    = '0;

    gpio_rsp_t awaited_rsp[$];
    int        mismatch_count = 0;
    bit        allow_idle     = 1'b1;
    bit        hold_rsp       = 1'b0;

    gpio_port_with_interrupt_detect_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Apply one request to the shadow registers and work out its response
    task automatic shadow_port_update(input gpio_req_t r, output gpio_rsp_t o);
        logic [31:0] lv;
        logic [31:0] rise;
        logic [31:0] fall;
        logic [31:0] hit;
        logic [31:0] pending;
        logic [1:0]  code;
        logic        fire;
        int          pin;
        o = '0;
        case (r.command)
            CMD_READ:
            begin
                case (r.reg_index)
                    REG_DATA:   o.read_data = (sh_data_out & sh_direction) |
                                              (sh_pad_status & ~sh_direction);
                    REG_DIR:    o.read_data = sh_direction;
                    REG_PAD:    o.read_data = sh_pad_status;
                    REG_ICR_LO: o.read_data = sh_icr_lower;
                    REG_ICR_HI: o.read_data = sh_icr_upper;
                    REG_MASK:   o.read_data = sh_irq_mask;
                    REG_STATUS: o.read_data = sh_irq_status;
                    default:    o.read_data = sh_any_edge;
                endcase
            end
            CMD_WRITE:
            begin
                case (r.reg_index)
                    REG_DATA:   sh_data_out   = r.write_data & PIN_MASK;
                    REG_DIR:    sh_direction  = r.write_data & PIN_MASK;
                    REG_PAD:    ;
                    REG_ICR_LO: sh_icr_lower  = r.write_data;
                    REG_ICR_HI: sh_icr_upper  = r.write_data;
                    REG_MASK:   sh_irq_mask   = r.write_data & PIN_MASK;
                    REG_STATUS: sh_irq_status = sh_irq_status & ~(r.write_data & PIN_MASK);
                    default:    sh_any_edge   = r.write_data & PIN_MASK;
                endcase
            end
            CMD_TICK:
            begin
                lv   = r.pin_levels & PIN_MASK;
                rise = lv & ~sh_prev_levels;
                fall = sh_prev_levels & ~lv;
                hit  = '0;
                for (pin = 0; pin < PIN_COUNT; pin++)
                begin
                    if (pin < HALF_PINS)
                        code = sh_icr_lower[2 * pin +: 2];
                    else
                        code = sh_icr_upper[2 * (pin - HALF_PINS) +: 2];
                    // any-edge select overrides the control code
                    if (sh_any_edge[pin])
                        fire = rise[pin] | fall[pin];
                    else
                    begin
                        case (code)
                            TRIG_LOW:  fire = ~lv[pin];
                            TRIG_HIGH: fire = lv[pin];
                            TRIG_RISE: fire = rise[pin];
                            default:   fire = fall[pin];
                        endcase
                    end
                    hit[pin] = fire;
                end
                sh_irq_status  = sh_irq_status | (hit & PIN_MASK);
                sh_prev_levels = lv;
                sh_pad_status  = lv;
            end
            default: ;
        endcase
        pending         = sh_irq_status & sh_irq_mask;
        o.pad_drive     = sh_data_out;
        o.pad_enable    = sh_direction;
        o.irq_low_half  = |pending[15:0];
        o.irq_high_half = |pending[31:16];
    endtask

    function automatic gpio_req_t build_request(logic [1:0] cmd, logic [2:0] idx,
                                                logic [31:0] wdata, logic [31:0] levels);
        gpio_req_t r;
        r.command    = cmd;
        r.reg_index  = idx;
        r.write_data = wdata;
        r.pin_levels = levels;
        return r;
    endfunction

    // Ticks most often, many with a few toggling pins, then register writes, reads and a rare unused command
    function automatic gpio_req_t random_request();
        gpio_req_t   r;
        int unsigned pick;
        r = build_request(CMD_READ, 3'($urandom_range(0, 7)), $urandom, $urandom);
        pick = $urandom_range(0, 99);
        if (pick < 40)
        begin
            r.command = CMD_TICK;
            case ($urandom_range(0, 3))
                0:       r.pin_levels = $urandom;
                3:       r.pin_levels = sh_prev_levels;
                default: r.pin_levels = sh_prev_levels ^ ($urandom & $urandom & $urandom);
            endcase
        end
        else if (pick < 72)
        begin
            r.command = CMD_WRITE;
            case ($urandom_range(0, 7))
                0:       r.write_data = '0;
                1:       r.write_data = ONES;
                default: ;
            endcase
        end
        else if (pick >= 97)
            r.command = CMD_UNUSED;
        return r;
    endfunction

    // Offer one request, wait for it to be taken, then log its expected response
    task automatic send_request(input gpio_req_t r);
        gpio_rsp_t want;
        if (allow_idle && $urandom_range(0, 7) == 0)
        begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge clk);
        end
        req       <= r;
        req_valid <= 1'b1;
        @(posedge clk);
        while (!req_ready) @(posedge clk);
        shadow_port_update(r, want);
        awaited_rsp.push_back(want);
    endtask

    task automatic report_mismatch(input string field, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("[%0t] mismatch on %s: got %h, expected %h", $realtime, field, got, want);
        mismatch_count++;
    endtask

    // Response side: random stalls, plus one long hold on request
    initial
    begin : rsp_side
        rsp_ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_rsp)
            begin
                rsp_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_rsp = 1'b0;
                rsp_ready <= 1'b1;
            end
            else if (allow_idle && $urandom_range(0, 11) == 0)
            begin
                rsp_ready <= 1'b0;
                repeat ($urandom_range(1, 13)) @(posedge clk);
                rsp_ready <= 1'b1;
            end
            else
                rsp_ready <= 1'b1;
        end
    end

    // Compare each response with the oldest expectation
    always @(posedge clk)
    begin : rsp_check
        gpio_rsp_t want;
        if (rst_n && rsp_valid && rsp_ready)
        begin
            if (awaited_rsp.size() == 0)
            begin
                $display("[%0t] response with nothing outstanding", $realtime);
                mismatch_count++;
            end
            else
            begin
                want = awaited_rsp.pop_front();
                if (rsp.read_data !== want.read_data)
                    report_mismatch("read_data", rsp.read_data, want.read_data);
                if (rsp.pad_drive !== want.pad_drive)
                    report_mismatch("pad_drive", rsp.pad_drive, want.pad_drive);
                if (rsp.pad_enable !== want.pad_enable)
                    report_mismatch("pad_enable", rsp.pad_enable, want.pad_enable);
                if (rsp.irq_low_half !== want.irq_low_half)
                    report_mismatch("irq_low_half", 32'(rsp.irq_low_half),
                                    32'(want.irq_low_half));
                if (rsp.irq_high_half !== want.irq_high_half)
                    report_mismatch("irq_high_half", 32'(rsp.irq_high_half),
                                    32'(want.irq_high_half));
            end
        end
    end

    // Watchdog: too long without any handshake ends the run
    initial
    begin : watchdog
        int quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("FAIL");
        $finish;
    end

    // First tick after reset sees every high pin as a rising edge
    task automatic test_first_tick();
        send_request(build_request(CMD_WRITE, REG_ICR_LO, 32'hAAAA_AAAA, '0));
        send_request(build_request(CMD_WRITE, REG_ICR_HI, 32'hAAAA_AAAA, '0));
        send_request(build_request(CMD_WRITE, REG_MASK, ONES, '0));
        send_request(build_request(CMD_TICK, REG_DATA, '0, ONES));
        send_request(build_request(CMD_READ, REG_STATUS, '0, '0));
    endtask

    // Clear by writing ones; a held high level sets its bit again at once; upper pins then fire on a fall
    task automatic test_level_and_clear();
        send_request(build_request(CMD_WRITE, REG_ICR_LO, 32'h5555_5555, '0));
        send_request(build_request(CMD_WRITE, REG_STATUS, ONES, '0));
        send_request(build_request(CMD_TICK, REG_DATA, '0, ONES));
        send_request(build_request(CMD_WRITE, REG_ICR_HI, ONES, '0));
        send_request(build_request(CMD_TICK, REG_DATA, '0, '0));
        send_request(build_request(CMD_READ, REG_STATUS, '0, '0));
    endtask

    // Any-edge select overrides a low-level code
    task automatic test_any_edge();
        send_request(build_request(CMD_WRITE, REG_STATUS, ONES, '0));
        send_request(build_request(CMD_WRITE, REG_ANY_EDGE, ONES, '0));
        send_request(build_request(CMD_WRITE, REG_ICR_LO, '0, '0));
        send_request(build_request(CMD_TICK, REG_DATA, '0, 32'h0000_FFFF));
        send_request(build_request(CMD_READ, REG_ANY_EDGE, '0, '0));
    endtask

    // Data read mixes drive and pad; pad status ignores writes; unused command
    task automatic test_register_map();
        send_request(build_request(CMD_WRITE, REG_DIR, 32'hFF00_FF00, '0));
        send_request(build_request(CMD_WRITE, REG_DATA, ONES, '0));
        send_request(build_request(CMD_READ, REG_DATA, '0, '0));
        send_request(build_request(CMD_WRITE, REG_PAD, ONES, '0));
        send_request(build_request(CMD_READ, REG_PAD, '0, '0));
        send_request(build_request(CMD_UNUSED, REG_ANY_EDGE, ONES, ONES));
        send_request(build_request(CMD_READ, REG_ICR_HI, '0, '0));
    endtask

    // Long response hold while requests keep coming
    task automatic test_response_hold();
        int n;
        allow_idle = 1'b0;
        hold_rsp   = 1'b1;
        for (n = 0; n < 20; n++)
            send_request(random_request());
        allow_idle = 1'b1;
    endtask

    // Random traffic, alternating stretches with and without idling
    task automatic test_random_traffic(input int count);
        int n;
        for (n = 0; n < count; n++)
        begin
            if (n % 40 == 0)
                allow_idle = (n % 80 == 0);
            send_request(random_request());
        end
    endtask

    // Back-to-back tail with both sides always ready
    task automatic test_full_rate_tail(input int count);
        int n;
        allow_idle = 1'b0;
        for (n = 0; n < count; n++)
            send_request(random_request());
    endtask

    initial
    begin
        rst_n     <= 1'b0;
        req_valid <= 1'b0;
        req       <= '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_first_tick();
        test_level_and_clear();
        test_any_edge();
        test_register_map();
        test_response_hold();
        test_random_traffic(320);
        test_full_rate_tail(80);

        req_valid <= 1'b0;
        while (awaited_rsp.size() != 0) @(posedge clk);
        repeat (8) @(posedge clk);
        if (mismatch_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

/* files.f */
rtl/gpio_irq_pkg.sv
rtl/gpio_irq_detect.sv
rtl/gpio_port_with_interrupt_detect_unit.sv
tb/gpio_port_with_interrupt_detect_unit_tb.sv
